/* rtl/drf_pkg.sv */
// Package for the deadband report filter: field widths, register indexes,
// register reset values and the configuration struct. No dependencies.
`default_nettype none
package drf_pkg;

  localparam int TimeW  = 32;
  localparam int TempW  = 15;
  localparam int HumidW = 14;
  localparam int PressW = 17;
  localparam int GapW   = 16;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  typedef logic        [TimeW-1:0]  time_t;
  typedef logic signed [TempW-1:0]  temp_t;
  typedef logic        [HumidW-1:0] humid_t;
  typedef logic        [PressW-1:0] press_t;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_GAP     = 8'd0,
    REG_HEARTBEAT   = 8'd1,
    REG_TEMP_DELTA  = 8'd2,
    REG_HUMID_DELTA = 8'd3,
    REG_PRESS_DELTA = 8'd4,
    REG_TEMP_MIN    = 8'd5,
    REG_TEMP_MAX    = 8'd6,
    REG_HUMID_MAX   = 8'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [GapW-1:0] min_gap;
    time_t           heartbeat;
    humid_t          temp_delta;
    humid_t          humid_delta;
    press_t          press_delta;
    temp_t           temp_min;
    temp_t           temp_max;
    humid_t          humid_max;
  } cfg_t;

  localparam logic [GapW-1:0] RstMinGap     = 16'd2000;
  localparam time_t           RstHeartbeat  = 32'd600000;
  localparam humid_t          RstTempDelta  = 14'd200;
  localparam humid_t          RstHumidDelta = 14'd200;
  localparam press_t          RstPressDelta = 17'd200;
  localparam temp_t           RstTempMin    = -15'sd4000;
  localparam temp_t           RstTempMax    = 15'sd8000;
  localparam humid_t          RstHumidMax   = 14'd10000;

endpackage
`default_nettype wire

/* rtl/drf_if.sv */
// Channel interfaces for the deadband report filter: sample input, result
// output and configuration write. Depends on drf_pkg.
`default_nettype none

interface drf_in_if;
  import drf_pkg::*;
  logic  valid;
  logic  ready;
  time_t  time_ms;
  temp_t  temperature;
  humid_t humidity;
  press_t pressure;
  modport source (output valid, time_ms, temperature, humidity, pressure, input ready);
  modport sink   (input valid, time_ms, temperature, humidity, pressure, output ready);
endinterface

interface drf_out_if;
  import drf_pkg::*;
  logic   valid;
  logic   ready;
  logic   sampled;
  logic   report;
  temp_t  temperature_out;
  humid_t humidity_out;
  press_t pressure_out;
  modport source (output valid, sampled, report, temperature_out, humidity_out,
                  pressure_out, input ready);
  modport sink   (input valid, sampled, report, temperature_out, humidity_out,
                  pressure_out, output ready);
endinterface

interface drf_cfg_if;
  import drf_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/deadband_report_filter_top.sv */
// Deadband report filter: send-on-delta sample filter with heartbeat.
// Depends on drf_pkg and the channel interfaces in drf_if.sv.
//
//  Channel  Role    Request carries
//  in_ch    sink    time_ms, temperature, humidity, pressure
//  out_ch   source  sampled, report, temperature_out, humidity_out, pressure_out
//  cfg_ch   sink    index, data (register write, always ready)
//
// A request is captured in the input register, evaluated combinationally
// against the stored report state and written to the result register; one
// request per cycle is sustained unless the result stalls. Stored state is
// updated at the same edge as the result; the next request sees it at once.
// Synchronous active-low reset restores register defaults and clears state.
// A stalled result holds the input register; a new request is taken in the
// cycle the result is taken.
`default_nettype none
module deadband_report_filter_top (
  input  wire logic clk,
  input  wire logic rst_n,
  drf_in_if.sink    in_ch,
  drf_out_if.source out_ch,
  drf_cfg_if.sink   cfg_ch
);
  import drf_pkg::*;

  cfg_t   cfg_r;
  logic   s1_valid_r;
  time_t  s1_time_r;
  temp_t  s1_temp_r;
  humid_t s1_humid_r;
  press_t s1_press_r;
  logic   out_valid_r;
  logic   out_sampled_r;
  logic   out_report_r;
  temp_t  out_temp_r;
  humid_t out_humid_r;
  press_t out_press_r;
  temp_t  last_temp_r;
  humid_t last_humid_r;
  press_t last_press_r;
  time_t  last_time_r;

  logic        advance;
  logic        s1_valid_nxt;
  time_t       elapsed;
  logic        sampled_c;
  logic        report_c;
  logic        change_c;
  logic        in_range_c;
  logic signed [TempW:0]   tdiff;
  logic signed [HumidW:0]  hdiff;
  logic signed [PressW:0]  pdiff;
  logic        [TempW:0]   tabs;
  logic        [HumidW:0]  habs;
  logic        [PressW:0]  pabs;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_gap     <= RstMinGap;
      cfg_r.heartbeat   <= RstHeartbeat;
      cfg_r.temp_delta  <= RstTempDelta;
      cfg_r.humid_delta <= RstHumidDelta;
      cfg_r.press_delta <= RstPressDelta;
      cfg_r.temp_min    <= RstTempMin;
      cfg_r.temp_max    <= RstTempMax;
      cfg_r.humid_max   <= RstHumidMax;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MIN_GAP:     cfg_r.min_gap     <= cfg_ch.data[GapW-1:0];
        REG_HEARTBEAT:   cfg_r.heartbeat   <= cfg_ch.data[TimeW-1:0];
        REG_TEMP_DELTA:  cfg_r.temp_delta  <= cfg_ch.data[HumidW-1:0];
        REG_HUMID_DELTA: cfg_r.humid_delta <= cfg_ch.data[HumidW-1:0];
        REG_PRESS_DELTA: cfg_r.press_delta <= cfg_ch.data[PressW-1:0];
        REG_TEMP_MIN:    cfg_r.temp_min    <= cfg_ch.data[TempW-1:0];
        REG_TEMP_MAX:    cfg_r.temp_max    <= cfg_ch.data[TempW-1:0];
        REG_HUMID_MAX:   cfg_r.humid_max   <= cfg_ch.data[HumidW-1:0];
        default: ;
      endcase
    end
  end

  // The input register moves on whenever the result register is free or
  // is being emptied in this cycle.
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign s1_valid_nxt = in_ch.valid || (s1_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_time_r  <= in_ch.time_ms;
      s1_temp_r  <= in_ch.temperature;
      s1_humid_r <= in_ch.humidity;
      s1_press_r <= in_ch.pressure;
    end
  end

  always_comb begin
    elapsed   = s1_time_r - last_time_r;
    sampled_c = elapsed >= {{(TimeW-GapW){1'b0}}, cfg_r.min_gap};

    tdiff = {s1_temp_r[TempW-1], s1_temp_r} - {last_temp_r[TempW-1], last_temp_r};
    hdiff = $signed({1'b0, s1_humid_r}) - $signed({1'b0, last_humid_r});
    pdiff = $signed({1'b0, s1_press_r}) - $signed({1'b0, last_press_r});
    tabs  = tdiff[TempW]  ? unsigned'(-tdiff) : unsigned'(tdiff);
    habs  = hdiff[HumidW] ? unsigned'(-hdiff) : unsigned'(hdiff);
    pabs  = pdiff[PressW] ? unsigned'(-pdiff) : unsigned'(pdiff);

    change_c = (elapsed >= cfg_r.heartbeat)
            || (tabs >= {2'b00, cfg_r.temp_delta})
            || (habs >= {1'b0, cfg_r.humid_delta})
            || (pabs >= {1'b0, cfg_r.press_delta});
    in_range_c = (s1_temp_r >= cfg_r.temp_min) && (s1_temp_r <= cfg_r.temp_max)
              && (s1_humid_r <= cfg_r.humid_max);
    report_c = sampled_c && change_c && in_range_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_temp_r  <= '0;
      last_humid_r <= '0;
      last_press_r <= '0;
      last_time_r  <= '0;
    end else if (advance && report_c) begin
      last_temp_r  <= s1_temp_r;
      last_humid_r <= s1_humid_r;
      last_press_r <= s1_press_r;
      last_time_r  <= s1_time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_sampled_r <= sampled_c;
      out_report_r  <= report_c;
      out_temp_r    <= report_c ? s1_temp_r  : last_temp_r;
      out_humid_r   <= report_c ? s1_humid_r : last_humid_r;
      out_press_r   <= report_c ? s1_press_r : last_press_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.sampled         = out_sampled_r;
  assign out_ch.report          = out_report_r;
  assign out_ch.temperature_out = out_temp_r;
  assign out_ch.humidity_out    = out_humid_r;
  assign out_ch.pressure_out    = out_press_r;

  // A report is only ever made for a sample that passed the minimum gap.
  a_report_needs_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_report_r || out_sampled_r))
    else $error("report without sampled");

  // A stalled result must hold back the input register.
  a_no_advance_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !advance)
    else $error("input register advanced over a stalled result");

  // The report time moves only when a request is reported.
  a_time_only_on_report: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(last_time_r)) |-> $past(advance && report_c))
    else $error("report time changed without a report");

  // The result carries the stored state as it stands after its own request.
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    $past(advance) |-> (out_temp_r == last_temp_r && out_humid_r == last_humid_r
                        && out_press_r == last_press_r))
    else $error("result does not match stored state");

endmodule
`default_nettype wire
